### src/kcl_pkg.sv
// ---------------------------------------------------------------------------
// kcl_pkg
// Types and constants shared by the keypad code lock files.
// ---------------------------------------------------------------------------
package kcl_pkg;

  // register file layout
  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned REG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CODE_WORD     = 3'd0,
    REG_MAX_WRONG     = 3'd1,
    REG_BEEP_TICKS    = 3'd2,
    REG_ALARM_TICKS   = 3'd3,
    REG_LOCKOUT_TICKS = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [31:0] CODE_WORD_RST     = 32'h3132_3334;
  localparam logic [3:0]  MAX_WRONG_RST     = 4'd3;
  localparam logic [15:0] BEEP_TICKS_RST    = 16'd250;
  localparam logic [15:0] ALARM_TICKS_RST   = 16'd2000;
  localparam logic [15:0] LOCKOUT_TICKS_RST = 16'd10000;

  typedef struct packed {
    logic [31:0] code_word;
    logic [3:0]  max_wrong;
    logic [15:0] beep_ticks;
    logic [15:0] alarm_ticks;
    logic [15:0] lockout_ticks;
  } cfg_t;

  // request kind on the input stream
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_CORRECT = 2'd1,
    VERDICT_WRONG   = 2'd2,
    VERDICT_LOCKOUT = 2'd3
  } verdict_t;

  // fixed 4x4 keypad layout, position is row*4+col
  function automatic logic [7:0] key_ascii(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:  c = "1";
      4'd1:  c = "2";
      4'd2:  c = "3";
      4'd3:  c = "A";
      4'd4:  c = "4";
      4'd5:  c = "5";
      4'd6:  c = "6";
      4'd7:  c = "B";
      4'd8:  c = "7";
      4'd9:  c = "8";
      4'd10: c = "9";
      4'd11: c = "C";
      4'd12: c = "*";
      4'd13: c = "0";
      4'd14: c = "#";
      4'd15: c = "D";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

### src/kcl_regs.sv
// ---------------------------------------------------------------------------
// kcl_regs
// APB-style configuration registers of the keypad code lock.
// ---------------------------------------------------------------------------
module kcl_regs
  import kcl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [REG_DATA_W-1:0] pwdata,
  output logic [REG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_word     <= CODE_WORD_RST;
      cfg.max_wrong     <= MAX_WRONG_RST;
      cfg.beep_ticks    <= BEEP_TICKS_RST;
      cfg.alarm_ticks   <= ALARM_TICKS_RST;
      cfg.lockout_ticks <= LOCKOUT_TICKS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CODE_WORD:     cfg.code_word     <= pwdata;
        REG_MAX_WRONG:     cfg.max_wrong     <= pwdata[3:0];
        REG_BEEP_TICKS:    cfg.beep_ticks    <= pwdata[15:0];
        REG_ALARM_TICKS:   cfg.alarm_ticks   <= pwdata[15:0];
        REG_LOCKOUT_TICKS: cfg.lockout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CODE_WORD:     prdata = cfg.code_word;
      REG_MAX_WRONG:     prdata = {28'd0, cfg.max_wrong};
      REG_BEEP_TICKS:    prdata = {16'd0, cfg.beep_ticks};
      REG_ALARM_TICKS:   prdata = {16'd0, cfg.alarm_ticks};
      REG_LOCKOUT_TICKS: prdata = {16'd0, cfg.lockout_ticks};
      default:           prdata = '0;
    endcase
  end

endmodule

### src/keypad_code_lock.sv
// output: the result of an accepted request is registered on m_tdata in the next cycle
// throughput: one request per cycle while results are taken, set by the single output
// register that holds the result while the downstream side stalls
// reset: synchronous, active high; clears key memory, entry and wrong
// counts, all timers and the output valid; registers return to defaults
// ---------------------------------------------------------------------------
// keypad_code_lock
// Keypad code lock: key edge detect, code entry and compare, wrong count,
// beep, alarm and lockout timers driven by tick requests.
// ---------------------------------------------------------------------------
module keypad_code_lock
  import kcl_pkg::*;
#(
  parameter int CODE_LENGTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // row[1:0], col[3:2], pressed[4], zero[7:5]
  input  logic                  s_tuser,   // operation[0]
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // key_valid[0], key_char[8:1], verdict[10:9],
                                           // alert[11], buzzer_on[12], locked[13], zero[15:14]
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [REG_DATA_W-1:0] pwdata,
  output logic [REG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // entry counter only needs to reach CODE_LENGTH-1 before wrapping to zero
  localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  cfg_t cfg;

  kcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // lock state
  logic [15:0]      key_was_pressed;
  logic [7:0]       entry_buf [CODE_LENGTH];
  logic [CNT_W-1:0] entry_count;
  logic [3:0]       wrong_count;
  logic [15:0]      beep_remaining;
  logic [15:0]      alarm_remaining;
  logic [15:0]      lock_remaining;

  logic [CNT_W-1:0] entry_count_next;
  logic [3:0]       wrong_count_next;
  logic [15:0]      beep_remaining_next;
  logic [15:0]      alarm_remaining_next;
  logic [15:0]      lock_remaining_next;

  // request fields
  logic       in_fire;
  op_t        op;
  logic [1:0] row;
  logic [1:0] col;
  logic       pressed;
  logic [3:0] pos;

  assign op      = op_t'(s_tuser);
  assign row     = s_tdata[1:0];
  assign col     = s_tdata[3:2];
  assign pressed = s_tdata[4];
  assign pos     = {row, col};

  // accept whenever the result register is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  logic       is_locked;
  logic       sample_live;
  logic       key_hit;
  logic [7:0] key_char;
  logic       entry_full;
  logic [3:0] wrong_inc;

  assign is_locked   = (alarm_remaining != 16'd0) || (lock_remaining != 16'd0);
  assign sample_live = (op == OP_SAMPLE) && !is_locked;
  // new press: position reads pressed and its stored level was released
  assign key_hit     = sample_live && pressed && !key_was_pressed[pos];
  assign key_char    = key_ascii(pos);
  assign entry_full  = (entry_count == CNT_W'(CODE_LENGTH - 1));
  assign wrong_inc   = wrong_count + 4'd1;

  // expected code bytes, first key in the highest used byte of code_word
  logic [7:0]             want [CODE_LENGTH];
  logic [CODE_LENGTH-1:0] byte_ok;

  for (genvar gi = 0; gi < CODE_LENGTH; gi++) begin : g_cmp
    localparam int SH = 8 * (CODE_LENGTH - 1 - gi);
    if (SH < 32) begin : g_in
      assign want[gi] = cfg.code_word[SH +: 8];
    end else begin : g_zero
      assign want[gi] = 8'd0;
    end
    // the last key is still on its way in, so compare it straight from the map
    if (gi == CODE_LENGTH - 1) begin : g_last
      assign byte_ok[gi] = (key_char == want[gi]);
    end else begin : g_buf
      assign byte_ok[gi] = (entry_buf[gi] == want[gi]);
    end
  end

  logic     entry_match;
  verdict_t verdict;
  logic     alert;

  assign entry_match = &byte_ok;

  always_comb begin
    entry_count_next     = entry_count;
    wrong_count_next     = wrong_count;
    beep_remaining_next  = beep_remaining;
    alarm_remaining_next = alarm_remaining;
    lock_remaining_next  = lock_remaining;
    verdict              = VERDICT_NONE;
    alert                = 1'b0;

    if (op == OP_TICK) begin
      if (beep_remaining != 16'd0) begin
        beep_remaining_next = beep_remaining - 16'd1;
      end
      // silent lockout only runs down once the alarm is over
      if (alarm_remaining != 16'd0) begin
        alarm_remaining_next = alarm_remaining - 16'd1;
      end else if (lock_remaining != 16'd0) begin
        lock_remaining_next = lock_remaining - 16'd1;
      end
    end else if (key_hit) begin
      beep_remaining_next = cfg.beep_ticks;
      if (entry_full) begin
        entry_count_next = '0;
        if (entry_match) begin
          verdict = VERDICT_CORRECT;
        end else if (wrong_inc >= cfg.max_wrong) begin
          verdict              = VERDICT_LOCKOUT;
          alert                = 1'b1;
          wrong_count_next     = 4'd0;
          alarm_remaining_next = cfg.alarm_ticks;
          lock_remaining_next  = cfg.lockout_ticks;
        end else begin
          verdict          = VERDICT_WRONG;
          wrong_count_next = wrong_inc;
        end
      end else begin
        entry_count_next = entry_count + CNT_W'(1);
      end
    end
  end

  // state update on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      key_was_pressed <= '0;
      entry_count     <= '0;
      wrong_count     <= '0;
      beep_remaining  <= '0;
      alarm_remaining <= '0;
      lock_remaining  <= '0;
    end else if (in_fire) begin
      // edge memory is frozen while locked
      if (sample_live) begin
        key_was_pressed[pos] <= pressed;
      end
      entry_count     <= entry_count_next;
      wrong_count     <= wrong_count_next;
      beep_remaining  <= beep_remaining_next;
      alarm_remaining <= alarm_remaining_next;
      lock_remaining  <= lock_remaining_next;
    end
  end

  // entry buffer, no reset: each slot is written before it is compared
  always_ff @(posedge clk) begin
    if (in_fire && key_hit) begin
      entry_buf[entry_count] <= key_char;
    end
  end

  // result register
  logic [15:0] result;

  always_comb begin
    result        = '0;
    result[0]     = key_hit;
    result[8:1]   = key_hit ? key_char : 8'd0;
    result[10:9]  = verdict;
    result[11]    = alert;
    result[12]    = (beep_remaining_next != 16'd0) || (alarm_remaining_next != 16'd0);
    result[13]    = (alarm_remaining_next != 16'd0) || (lock_remaining_next != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= result;
    end
  end

endmodule

### src/kcl_checker.sv
// ---------------------------------------------------------------------------
// kcl_checker
// Port-level checks of the keypad code lock, bound to the top level.
// ---------------------------------------------------------------------------
module kcl_checker
  import kcl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an empty result register never blocks the input side
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // alert comes exactly with the lockout verdict
  a_alert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11] == (m_tdata[10:9] == VERDICT_LOCKOUT)))
    else $error("alert and lockout verdict disagree");

  // a verdict only follows an accepted key
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[10:9] != VERDICT_NONE) |-> m_tdata[0])
    else $error("verdict without an accepted key");

  // no result is pending right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad code lock. A lock tracker class keeps
// its own copy of key memory, entry, wrong count and timers, predicts one
// result per request and checks the result stream in order. Requests are
// directed corner cases first, then random phases of key strokes, code
// entries, tick bursts and noise under several register settings.
// ---------------------------------------------------------------------------
module tb_top;
  import kcl_pkg::*;

  localparam int          CODE_LEN      = 4;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_ITEMS   = 140;
  // a register index with nothing behind it
  localparam logic [2:0]  SPARE_REG_IDX = 3'd6;
  // keypad layout, position row*4+col, position 0 in the top byte
  localparam logic [127:0] KEY_LAYOUT   = "123A456B789C*0#D";

  // one expected result, same field order as the result stream
  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_char;
    verdict_t   verdict;
    logic       alert;
    logic       buzzer_on;
    logic       locked;
  } lock_result_t;

  // ------------------------------------------------------------------------
  // lock tracker: predicts the lock and holds results still owed by the block
  // ------------------------------------------------------------------------
  class lock_tracker;
    cfg_t         cfg;
    logic [15:0]  held_keys;
    logic [7:0]   entry [CODE_LEN];
    int unsigned  entry_len;
    logic [3:0]   wrong_cnt;
    logic [15:0]  beep_left;
    logic [15:0]  alarm_left;
    logic [15:0]  lock_left;
    lock_result_t pending [$];
    int unsigned  errors;

    function new();
      cfg.code_word     = CODE_WORD_RST;
      cfg.max_wrong     = MAX_WRONG_RST;
      cfg.beep_ticks    = BEEP_TICKS_RST;
      cfg.alarm_ticks   = ALARM_TICKS_RST;
      cfg.lockout_ticks = LOCKOUT_TICKS_RST;
      held_keys  = '0;
      entry_len  = 0;
      wrong_cnt  = '0;
      beep_left  = '0;
      alarm_left = '0;
      lock_left  = '0;
      errors     = 0;
    endfunction

    function bit locked_now();
      return alarm_left != 0 || lock_left != 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_CODE_WORD:     cfg.code_word     = value;
        REG_MAX_WRONG:     cfg.max_wrong     = value[3:0];
        REG_BEEP_TICKS:    cfg.beep_ticks    = value[15:0];
        REG_ALARM_TICKS:   cfg.alarm_ticks   = value[15:0];
        REG_LOCKOUT_TICKS: cfg.lockout_ticks = value[15:0];
        default: ;
      endcase
    endfunction

    // first key sits in the top byte of the code word
    function bit entry_is_code();
      for (int i = 0; i < CODE_LEN; i++) begin
        if (entry[i] != cfg.code_word[8*(CODE_LEN-1-i) +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(op_t op, logic [1:0] row, logic [1:0] col, logic pressed);
      lock_result_t r;
      int           pos;
      r   = '0;
      pos = {row, col};
      if (op == OP_TICK) begin
        if (beep_left != 0) beep_left--;
        // the silent lockout only runs down once the alarm is over
        if (alarm_left != 0) alarm_left--;
        else if (lock_left != 0) lock_left--;
      end else if (!locked_now()) begin
        if (pressed && !held_keys[pos]) begin
          r.key_valid = 1'b1;
          r.key_char  = KEY_LAYOUT[8*(15-pos) +: 8];
          if (entry_len < CODE_LEN) entry[entry_len] = r.key_char;
          entry_len++;
          beep_left = cfg.beep_ticks;
          if (entry_len >= CODE_LEN) begin
            if (entry_is_code()) begin
              r.verdict = VERDICT_CORRECT;
            end else begin
              r.verdict = VERDICT_WRONG;
              wrong_cnt = wrong_cnt + 4'd1;
              if (wrong_cnt >= cfg.max_wrong) begin
                r.verdict  = VERDICT_LOCKOUT;
                r.alert    = 1'b1;
                wrong_cnt  = '0;
                alarm_left = cfg.alarm_ticks;
                lock_left  = cfg.lockout_ticks;
              end
            end
            entry_len = 0;
          end
        end
        held_keys[pos] = pressed;
      end
      r.buzzer_on = beep_left != 0 || alarm_left != 0;
      r.locked    = locked_now();
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [15:0] data);
      lock_result_t want;
      if (pending.size() == 0) begin
        $error("result %h arrived with no request outstanding", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("key_valid", want.key_valid, data[0]);
      compare_field("key_char",  want.key_char,  data[8:1]);
      compare_field("verdict",   want.verdict,   data[10:9]);
      compare_field("alert",     want.alert,     data[11]);
      compare_field("buzzer_on", want.buzzer_on, data[12]);
      compare_field("locked",    want.locked,    data[13]);
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // block under test
  // ------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;   // row[1:0], col[3:2], pressed[4], zero[7:5]
  logic                  s_tuser;   // operation[0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [15:0]           m_tdata;   // key_valid[0], key_char[8:1], verdict[10:9],
                                    // alert[11], buzzer_on[12], locked[13], zero[15:14]
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [REG_DATA_W-1:0] pwdata;
  logic [REG_DATA_W-1:0] prdata;
  logic                  pready;

  keypad_code_lock uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lock_tracker tracker = new();

  int unsigned sent_in_phase;
  int unsigned cycle_count = 0;
  bit          send_calm;          // sender runs without gaps while set
  bit          recv_calm = 1'b0;   // receiver runs without stalls while set
  logic [3:0]  code_keys [CODE_LEN];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog, a hung handshake ends the run here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  // both handshakes are sampled at the edge, before anything driven there lands
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) tracker.check_result(m_tdata);
      if (s_tvalid && s_tready) begin
        tracker.note_request(op_t'(s_tuser), s_tdata[1:0], s_tdata[3:2], s_tdata[4]);
      end
    end
  end

  // receiver: random stall before each result, with calm stretches
  initial begin
    m_tready = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      int unsigned stall;
      if ($urandom_range(0, 19) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // ------------------------------------------------------------------------
  // request driving
  // ------------------------------------------------------------------------

  // valid stays high into the next request when no gap is drawn
  task automatic send_request(op_t op, logic [1:0] row, logic [1:0] col, logic pressed);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, pressed, col, row};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_in_phase++;
  endtask

  task automatic press_key(logic [3:0] pos);
    send_request(OP_SAMPLE, pos[3:2], pos[1:0], 1'b1);
  endtask

  task automatic lift_key(logic [3:0] pos);
    send_request(OP_SAMPLE, pos[3:2], pos[1:0], 1'b0);
  endtask

  // tick with random don't-care content in the sample fields
  task automatic tick();
    send_request(OP_TICK, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
  endtask

  // press and let go, sometimes with a stray lift first or a tick while held
  task automatic key_stroke(logic [3:0] pos);
    if ($urandom_range(0, 9) < 3) lift_key(pos);
    press_key(pos);
    if ($urandom_range(0, 3) == 0) tick();
    lift_key(pos);
  endtask

  // hold off until every result owed has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // setup cycle, access cycle, then an idle gap so psel never drops and rises at once
  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, value);
    @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // random phase: one register setting, then mostly well-formed key work
  // ------------------------------------------------------------------------
  task automatic run_phase(logic [3:0] max_wrong, logic [15:0] beep, logic [15:0] alarm,
                           logic [15:0] lockout, bit keypad_code, logic [31:0] fixed_code);
    logic [31:0] code;
    int unsigned pick;
    drain();
    if (keypad_code) begin
      for (int i = 0; i < CODE_LEN; i++) begin
        code_keys[i] = 4'($urandom_range(0, 15));
        code[8*(CODE_LEN-1-i) +: 8] = KEY_LAYOUT[8*(15-code_keys[i]) +: 8];
      end
    end else begin
      code = fixed_code;
    end
    apb_write(REG_CODE_WORD, code);
    apb_write(REG_MAX_WRONG, {28'd0, max_wrong});
    apb_write(REG_BEEP_TICKS, {16'd0, beep});
    apb_write(REG_ALARM_TICKS, {16'd0, alarm});
    apb_write(REG_LOCKOUT_TICKS, {16'd0, lockout});
    sent_in_phase = 0;
    while (sent_in_phase < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) send_calm = !send_calm;
      // sender pauses now and then until the block has answered everything
      if ($urandom_range(0, 49) == 0) drain();
      pick = $urandom_range(0, 99);
      if (tracker.locked_now() && pick < 70) begin
        repeat ($urandom_range(1, 8)) tick();
      end else if (pick < 40) begin
        // a full entry, the real code when it is made of keypad characters
        for (int i = 0; i < CODE_LEN; i++) begin
          key_stroke(keypad_code ? code_keys[i] : 4'($urandom_range(0, 15)));
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3)) key_stroke(4'($urandom_range(0, 15)));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) tick();
      end else begin
        send_request(op_t'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    send_calm   = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: tick with nothing running, then the default code
    tick();
    press_key(4'd0);
    press_key(4'd0);                 // still held, no new key
    lift_key(4'd0);
    press_key(4'd1);
    lift_key(4'd1);
    press_key(4'd2);
    lift_key(4'd2);
    press_key(4'd4);                 // completes the default code
    send_request(OP_TICK, 2'd3, 2'd3, 1'b1);

    // single wrong entry locks out, short alarm then silent lockout
    drain();
    apb_write(REG_MAX_WRONG, 32'd1);
    apb_write(REG_BEEP_TICKS, 32'd2);
    apb_write(REG_ALARM_TICKS, 32'd1);
    apb_write(REG_LOCKOUT_TICKS, 32'd2);
    press_key(4'd15);
    press_key(4'd14);
    press_key(4'd13);
    press_key(4'd12);                // wrong entry, alert and lockout
    press_key(4'd0);                 // ignored while locked
    // new lockout time only applies to the next lockout
    drain();
    apb_write(REG_LOCKOUT_TICKS, 32'd5);
    tick();                          // alarm ends, beep still on
    tick();
    press_key(4'd0);                 // still ignored, edge memory frozen
    tick();                          // lockout over
    lift_key(4'd15);

    // wrong limit of zero and zero times: any wrong entry locks out, and lockout starts and ends on the same request
    drain();
    apb_write(REG_MAX_WRONG, 32'd0);
    apb_write(REG_BEEP_TICKS, 32'd0);
    apb_write(REG_ALARM_TICKS, 32'd0);
    apb_write(REG_LOCKOUT_TICKS, 32'd0);
    apb_write(SPARE_REG_IDX, $urandom);   // no register there, must be dropped
    press_key(4'd0);
    press_key(4'd1);
    press_key(4'd2);
    press_key(4'd3);
    press_key(4'd15);

    // random phases, the extremes of every register among them
    run_phase(4'd3,  16'd5,     16'd3,     16'd6,     1'b1, 32'h0);
    run_phase(4'd15, 16'd65535, 16'd0,     16'd4,     1'b1, 32'h0);
    run_phase(4'd1,  16'd0,     16'd2,     16'd0,     1'b0, 32'hFFFF_FFFF);
    run_phase(4'd0,  16'd1,     16'd1,     16'd1,     1'b0, 32'h0000_0000);
    run_phase(4'd2,  16'd3,     16'd4,     16'd3,     1'b1, 32'h0);
    run_phase(4'd1,  16'd7,     16'd65535, 16'd65535, 1'b1, 32'h0);

    drain();
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
